[rtl/msixvt_pkg.sv]
// Shared types and constants for the MSI-X vector table and pending-bit block.
// Used by the command front end, the command queue, the execution back end and the top level.
`default_nettype none
package msixvt_pkg;

   localparam int MAX_VECTORS_DEF = 2048;

   localparam int OFF_W     = 15;
   localparam int SIZE_W    = 4;
   localparam int DWORD_W   = 32;
   localparam int QWORD_W   = 64;
   localparam int VNUM_W    = 11;
   localparam int COUNT_W   = 12;
   localparam int PBA_BIT_W = 6;
   localparam int PBA_Q_W   = 12;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [SIZE_W-1:0] ACCESS_DWORD = 4'd4;
   localparam logic [SIZE_W-1:0] ACCESS_QWORD = 4'd8;

   // CSR register indexes (byte address / 4)
   localparam logic [1:0] REG_ENABLE = 2'd0;
   localparam logic [1:0] REG_FMASK  = 2'd1;
   localparam logic [1:0] REG_COUNT  = 2'd2;

   typedef enum logic [1:0] {
      OP_TABLE_READ  = 2'd0,
      OP_TABLE_WRITE = 2'd1,
      OP_PBA_READ    = 2'd2,
      OP_TRIGGER     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_IGNORED = 2'd1,
      ST_PENDING = 2'd2,
      ST_RANGE   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      K_IGNORED     = 3'd0,
      K_RANGE       = 3'd1,
      K_TABLE_READ  = 3'd2,
      K_TABLE_WRITE = 3'd3,
      K_PBA_READ    = 3'd4,
      K_TRIGGER     = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      FLD_ADDR_LO = 2'd0,
      FLD_ADDR_HI = 2'd1,
      FLD_DATA    = 2'd2,
      FLD_CTRL    = 2'd3
   } field_type;

   typedef struct packed {
      kind_type               kind;
      logic [VNUM_W-1:0]      vec;
      field_type              field;
      logic [PBA_Q_W-1:0]     qword;
      logic [PBA_BIT_W-1:0]   bit_idx;
      logic                   qword_read;
      logic                   high_half;
      logic [DWORD_W-1:0]     wval;
   } cmd_type;

   typedef struct packed {
      logic               msix_enable;
      logic               function_mask;
      logic [COUNT_W-1:0] vectors_in_use;
   } csr_type;

endpackage
`default_nettype wire

[rtl/msixvt_cmd_fifo.sv]
// Short command queue between the front end and the back end.
// Depends on msixvt_pkg for the command type and queue depth.
`default_nettype none
module msixvt_cmd_fifo
   import msixvt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  cmd_type      push_cmd,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      head_cmd,
   output logic         empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

[rtl/msixvt_front.sv]
// Front end: takes request beats, range-checks them against the vector count
// and turns them into queue commands. Depends on msixvt_pkg.
`default_nettype none
module msixvt_front
   import msixvt_pkg::*;
#(
   parameter int MAX_VECTORS = MAX_VECTORS_DEF
) (
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_op,
   input  wire logic [OFF_W-1:0]   req_byte_offset,
   input  wire logic [SIZE_W-1:0]  req_access_bytes,
   input  wire logic [DWORD_W-1:0] req_write_value,
   input  wire logic [VNUM_W-1:0]  req_vector_number,
   input  csr_type                 csr,
   input  wire logic               busy,
   input  wire logic               queue_full,
   output logic                    push,
   output cmd_type                 push_cmd
);

   localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(MAX_VECTORS);

   logic [COUNT_W-1:0]   count;
   logic [COUNT_W:0]     words_sum;
   logic [PBA_Q_W-1:0]   words;
   logic [VNUM_W-1:0]    tab_vec;
   logic [PBA_Q_W-1:0]   pba_q;
   logic                 tab_bad;
   logic                 pba_bad;

   assign req_ready = !busy && !queue_full;
   assign push      = req_valid && req_ready;

   always_comb begin
      count     = (csr.vectors_in_use > MAX_N) ? MAX_N : csr.vectors_in_use;
      words_sum = {1'b0, count} + (COUNT_W + 1)'(QWORD_W - 1);
      words     = PBA_Q_W'(words_sum >> PBA_BIT_W);
      tab_vec   = req_byte_offset[OFF_W-1:4];
      pba_q     = req_byte_offset[OFF_W-1:3];
      tab_bad   = (req_access_bytes != ACCESS_DWORD) || (req_byte_offset[1:0] != 2'b00)
                  || ({1'b0, tab_vec} >= count);
      pba_bad   = ((req_access_bytes != ACCESS_DWORD) && (req_access_bytes != ACCESS_QWORD))
                  || (pba_q >= words);

      push_cmd            = '0;
      push_cmd.wval       = req_write_value;
      push_cmd.field      = field_type'(req_byte_offset[3:2]);
      push_cmd.qword_read = (req_access_bytes == ACCESS_QWORD);
      push_cmd.high_half  = req_byte_offset[2];
      case (op_type'(req_op))
         OP_TABLE_READ, OP_TABLE_WRITE: begin
            push_cmd.vec     = tab_vec;
            push_cmd.qword   = PBA_Q_W'(tab_vec[VNUM_W-1:PBA_BIT_W]);
            push_cmd.bit_idx = tab_vec[PBA_BIT_W-1:0];
            if (tab_bad) begin
               push_cmd.kind = K_IGNORED;
            end else if (op_type'(req_op) == OP_TABLE_READ) begin
               push_cmd.kind = K_TABLE_READ;
            end else begin
               push_cmd.kind = K_TABLE_WRITE;
            end
         end
         OP_PBA_READ: begin
            push_cmd.qword = pba_q;
            push_cmd.kind  = pba_bad ? K_IGNORED : K_PBA_READ;
         end
         OP_TRIGGER: begin
            push_cmd.vec     = req_vector_number;
            push_cmd.qword   = PBA_Q_W'(req_vector_number[VNUM_W-1:PBA_BIT_W]);
            push_cmd.bit_idx = req_vector_number[PBA_BIT_W-1:0];
            push_cmd.kind    = ({1'b0, req_vector_number} >= count) ? K_RANGE : K_TRIGGER;
         end
         default: begin
            push_cmd.kind = K_IGNORED;
         end
      endcase
   end

endmodule
`default_nettype wire

[rtl/msixvt_back.sv]
// Back end: clears the vector table after reset, then executes queued commands
// against the table memories and the pending-bit array. Depends on msixvt_pkg.
`default_nettype none
module msixvt_back
   import msixvt_pkg::*;
#(
   parameter int MAX_VECTORS = MAX_VECTORS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  csr_type                  csr,
   input  wire logic                queue_empty,
   input  cmd_type                  head_cmd,
   output logic                     pop,
   output logic                     busy,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [QWORD_W-1:0]       rsp_read_value,
   output logic                     rsp_message_valid,
   output logic [QWORD_W-1:0]       rsp_message_address,
   output logic [DWORD_W-1:0]       rsp_message_data,
   output logic [1:0]               rsp_status
);

   localparam int VEC_W = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
   localparam int PBA_D = (MAX_VECTORS + QWORD_W - 1) / QWORD_W;
   localparam int PBA_W = (PBA_D > 1) ? $clog2(PBA_D) : 1;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   state_type            state_ff;
   logic [VEC_W-1:0]     clr_idx_ff;
   cmd_type              cmd_ff;
   logic [QWORD_W-1:0]   pending_ff [PBA_D];

   logic [DWORD_W-1:0]   addr_lo_mem [MAX_VECTORS];
   logic [DWORD_W-1:0]   addr_hi_mem [MAX_VECTORS];
   logic [DWORD_W-1:0]   data_mem    [MAX_VECTORS];
   logic                 mask_mem    [MAX_VECTORS];
   logic [DWORD_W-1:0]   rd_lo_ff, rd_hi_ff, rd_data_ff;
   logic                 rd_mask_ff;

   logic                 rsp_valid_ff;
   logic [QWORD_W-1:0]   rsp_read_ff, rsp_maddr_ff;
   logic                 rsp_mvalid_ff;
   logic [DWORD_W-1:0]   rsp_mdata_ff;
   status_type           rsp_status_ff;

   logic                 clearing, exec;
   logic [VEC_W-1:0]     head_idx, wr_idx;
   logic [PBA_W-1:0]     q_idx;
   logic [QWORD_W-1:0]   pend_word, pend_word_in;
   logic                 pend_we;
   logic                 we_lo, we_hi, we_data, we_mask;
   logic [DWORD_W-1:0]   wr_dword;
   logic                 wr_mask;
   logic                 enabled;
   logic [QWORD_W-1:0]   res_read, res_maddr;
   logic                 res_mvalid;
   logic [DWORD_W-1:0]   res_mdata;
   status_type           res_status;

   assign clearing = (state_ff == S_CLEAR);
   assign exec     = (state_ff == S_EXEC);
   assign busy     = clearing;
   assign pop      = (state_ff == S_IDLE) && !queue_empty && (!rsp_valid_ff || rsp_ready);
   assign head_idx = head_cmd.vec[VEC_W-1:0];
   assign wr_idx   = clearing ? clr_idx_ff : cmd_ff.vec[VEC_W-1:0];
   assign q_idx    = cmd_ff.qword[PBA_W-1:0];
   assign pend_word = pending_ff[q_idx];
   assign enabled  = csr.msix_enable && !csr.function_mask;
   assign wr_dword = clearing ? '0 : cmd_ff.wval;
   assign wr_mask  = clearing ? 1'b0 : cmd_ff.wval[0];

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_value      = rsp_read_ff;
   assign rsp_message_valid   = rsp_mvalid_ff;
   assign rsp_message_address = rsp_maddr_ff;
   assign rsp_message_data    = rsp_mdata_ff;
   assign rsp_status          = rsp_status_ff;

   always_comb begin
      res_read     = '0;
      res_mvalid   = 1'b0;
      res_maddr    = '0;
      res_mdata    = '0;
      res_status   = ST_DONE;
      pend_word_in = pend_word;
      pend_we      = 1'b0;
      we_lo        = clearing;
      we_hi        = clearing;
      we_data      = clearing;
      we_mask      = clearing;
      case (cmd_ff.kind)
         K_IGNORED: begin
            res_status = ST_IGNORED;
         end
         K_RANGE: begin
            res_status = ST_RANGE;
         end
         K_TABLE_READ: begin
            case (cmd_ff.field)
               FLD_ADDR_LO: res_read = {32'd0, rd_lo_ff};
               FLD_ADDR_HI: res_read = {32'd0, rd_hi_ff};
               FLD_DATA:    res_read = {32'd0, rd_data_ff};
               default:     res_read = {63'd0, rd_mask_ff};
            endcase
         end
         K_TABLE_WRITE: begin
            case (cmd_ff.field)
               FLD_ADDR_LO: we_lo   = exec;
               FLD_ADDR_HI: we_hi   = exec;
               FLD_DATA:    we_data = exec;
               default: begin
                  we_mask = exec;
                  // unmasking a pending vector fires it straight away
                  if (rd_mask_ff && !cmd_ff.wval[0] && enabled && pend_word[cmd_ff.bit_idx]) begin
                     pend_word_in[cmd_ff.bit_idx] = 1'b0;
                     pend_we    = exec;
                     res_mvalid = 1'b1;
                     res_maddr  = {rd_hi_ff, rd_lo_ff};
                     res_mdata  = rd_data_ff;
                  end
               end
            endcase
         end
         K_PBA_READ: begin
            if (cmd_ff.qword_read) begin
               res_read = pend_word;
            end else if (cmd_ff.high_half) begin
               res_read = {32'd0, pend_word[QWORD_W-1:DWORD_W]};
            end else begin
               res_read = {32'd0, pend_word[DWORD_W-1:0]};
            end
         end
         K_TRIGGER: begin
            if (!enabled || rd_mask_ff) begin
               pend_word_in[cmd_ff.bit_idx] = 1'b1;
               pend_we    = exec;
               res_status = ST_PENDING;
            end else begin
               res_mvalid = 1'b1;
               res_maddr  = {rd_hi_ff, rd_lo_ff};
               res_mdata  = rd_data_ff;
            end
         end
         default: begin
            res_status = ST_IGNORED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PBA_D; i++) begin
            pending_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + 1'b1;
               if (clr_idx_ff == VEC_W'(MAX_VECTORS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (pop) begin
                  cmd_ff   <= head_cmd;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (pend_we) begin
                  pending_ff[q_idx] <= pend_word_in;
               end
               rsp_valid_ff  <= 1'b1;
               rsp_read_ff   <= res_read;
               rsp_mvalid_ff <= res_mvalid;
               rsp_maddr_ff  <= res_maddr;
               rsp_mdata_ff  <= res_mdata;
               rsp_status_ff <= res_status;
               state_ff      <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // table memories: read on pop, written by the clearing sweep or on execute
   always_ff @(posedge clock) begin
      if (we_lo) begin
         addr_lo_mem[wr_idx] <= wr_dword;
      end
      if (pop) begin
         rd_lo_ff <= addr_lo_mem[head_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (we_hi) begin
         addr_hi_mem[wr_idx] <= wr_dword;
      end
      if (pop) begin
         rd_hi_ff <= addr_hi_mem[head_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (we_data) begin
         data_mem[wr_idx] <= wr_dword;
      end
      if (pop) begin
         rd_data_ff <= data_mem[head_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (we_mask) begin
         mask_mem[wr_idx] <= wr_mask;
      end
      if (pop) begin
         rd_mask_ff <= mask_mem[head_idx];
      end
   end

endmodule
`default_nettype wire

[rtl/msix_vector_table_and_pending.sv]
// Top level of the MSI-X vector table and pending-bit block: CSR port, request
// and response streams. Depends on msixvt_pkg, msixvt_front, msixvt_cmd_fifo, msixvt_back.
`default_nettype none
// Each request beat is a table dword read or write, a PBA read or a vector
// trigger, and gives exactly one response beat in request order. Right after
// reset the block sweeps the vector table to zero, one entry per cycle;
// req_tready stays low for that time while CSR writes are still taken. After
// that, a beat enters a two-entry command queue in the cycle it is accepted.
// The execution side reads the table memories (registered read port) as it
// pops a command, then executes it, updates the pending bits and loads the
// response register; it pops the next command only once that is done. While
// a finished beat waits on rsp_tready the next command stays in the queue; it
// is read in the cycle that beat is taken. Change msix_enable, function_mask
// and vectors_in_use only while no request is in flight; a vector count above
// MAX_VECTORS acts as MAX_VECTORS, and a count of zero puts every vector out
// of range.
module msix_vector_table_and_pending
   import msixvt_pkg::*;
#(
   parameter int MAX_VECTORS = MAX_VECTORS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // request stream
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // [14:0] byte_offset, [18:15] access_bytes, [50:19] write_value,
   // [61:51] vector_number, [63:62] zero
   input  wire logic [63:0]   req_tdata,
   // [1:0] op
   input  wire logic [1:0]    req_tuser,
   // response stream
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // [63:0] read_value, [127:64] message_address, [159:128] message_data
   output logic [159:0]       rsp_tdata,
   // [0] message_valid, [2:1] status
   output logic [2:0]         rsp_tuser,
   // CSR port
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [3:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   csr_type               csr_ff;
   logic                  csr_wr;
   logic [1:0]            csr_idx;

   logic                  push, pop, queue_full, queue_empty, busy;
   cmd_type               push_cmd, head_cmd;

   logic [QWORD_W-1:0]    rsp_read_value, rsp_message_address;
   logic                  rsp_message_valid;
   logic [DWORD_W-1:0]    rsp_message_data;
   logic [1:0]            rsp_status;

   // CSR block: write on the access phase, reads straight from the registers
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.msix_enable    <= 1'b0;
         csr_ff.function_mask  <= 1'b0;
         csr_ff.vectors_in_use <= COUNT_W'(MAX_VECTORS_DEF);
      end else if (csr_wr) begin
         case (csr_idx)
            REG_ENABLE: csr_ff.msix_enable    <= csr_pwdata[0];
            REG_FMASK:  csr_ff.function_mask  <= csr_pwdata[0];
            REG_COUNT:  csr_ff.vectors_in_use <= csr_pwdata[COUNT_W-1:0];
            default: begin
               // unmapped register: drop the write
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ENABLE: csr_prdata = {31'd0, csr_ff.msix_enable};
         REG_FMASK:  csr_prdata = {31'd0, csr_ff.function_mask};
         REG_COUNT:  csr_prdata = {20'd0, csr_ff.vectors_in_use};
         default:    csr_prdata = '0;
      endcase
   end

   // classify and range-check each beat
   msixvt_front #(
      .MAX_VECTORS (MAX_VECTORS)
   ) u_front (
      .req_valid         (req_tvalid),
      .req_ready         (req_tready),
      .req_op            (req_tuser[1:0]),
      .req_byte_offset   (req_tdata[14:0]),
      .req_access_bytes  (req_tdata[18:15]),
      .req_write_value   (req_tdata[50:19]),
      .req_vector_number (req_tdata[61:51]),
      .csr               (csr_ff),
      .busy              (busy),
      .queue_full        (queue_full),
      .push              (push),
      .push_cmd          (push_cmd)
   );

   // decouple acceptance from execution
   msixvt_cmd_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty)
   );

   // table memories, pending bits and response register
   msixvt_back #(
      .MAX_VECTORS (MAX_VECTORS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .csr                 (csr_ff),
      .queue_empty         (queue_empty),
      .head_cmd            (head_cmd),
      .pop                 (pop),
      .busy                (busy),
      .rsp_valid           (rsp_tvalid),
      .rsp_ready           (rsp_tready),
      .rsp_read_value      (rsp_read_value),
      .rsp_message_valid   (rsp_message_valid),
      .rsp_message_address (rsp_message_address),
      .rsp_message_data    (rsp_message_data),
      .rsp_status          (rsp_status)
   );

   assign rsp_tdata = {rsp_message_data, rsp_message_address, rsp_read_value};
   assign rsp_tuser = {rsp_status, rsp_message_valid};

endmodule
`default_nettype wire

[verif/tb_msix_vector_table_and_pending.sv]
`timescale 1ns / 1ps
// Self-checking bench for msix_vector_table_and_pending: stream requests in, responses out,
// CSR writes over the APB-style port. Needs only msixvt_pkg and the RTL under rtl/.

import msixvt_pkg::*;

typedef struct packed {
   op_type       op;
   logic [10:0]  vnum;
   logic [31:0]  wval;
   logic [3:0]   size;
   logic [14:0]  off;
} msix_request;

typedef struct packed {
   logic [63:0]  read_value;
   logic         msg_valid;
   logic [63:0]  msg_addr;
   logic [31:0]  msg_data;
   status_type   status;
} msix_outcome;

// Shadow of the vector table, mask bits and pending-bit array; predicts one
// response per request and checks responses in order.
class vector_table_shadow;
   bit [63:0]   msg_addr_mem [MAX_VECTORS_DEF];
   bit [31:0]   msg_data_mem [MAX_VECTORS_DEF];
   bit          mask_mem [MAX_VECTORS_DEF];
   bit [63:0]   pba_mem [MAX_VECTORS_DEF / 64];
   bit          enable_reg;
   bit          fmask_reg;
   bit [11:0]   count_reg = 12'd2048;
   msix_outcome due_outcomes [$];
   int          mismatches;
   int          reported;

   function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
         REG_ENABLE: enable_reg = value[0];
         REG_FMASK:  fmask_reg = value[0];
         REG_COUNT:  count_reg = value[11:0];
         default: ;
      endcase
   endfunction

   function int live_vectors();
      return (count_reg > MAX_VECTORS_DEF) ? MAX_VECTORS_DEF : int'(count_reg);
   endfunction

   function void note_request(msix_request r);
      msix_outcome o;
      int          n;
      int          v;
      int          q;
      field_type   fld;
      bit          live;
      bit          was;
      n = live_vectors();
      live = enable_reg && !fmask_reg;
      o.read_value = '0;
      o.msg_valid = 1'b0;
      o.msg_addr = '0;
      o.msg_data = '0;
      o.status = ST_DONE;
      case (r.op)
         OP_TABLE_READ, OP_TABLE_WRITE: begin
            v = int'(r.off[14:4]);
            fld = field_type'(r.off[3:2]);
            if (r.size != ACCESS_DWORD || r.off[1:0] != 2'b00 || v >= n) begin
               o.status = ST_IGNORED;
            end else if (r.op == OP_TABLE_READ) begin
               case (fld)
                  FLD_ADDR_LO: o.read_value = {32'd0, msg_addr_mem[v][31:0]};
                  FLD_ADDR_HI: o.read_value = {32'd0, msg_addr_mem[v][63:32]};
                  FLD_DATA:    o.read_value = {32'd0, msg_data_mem[v]};
                  default:     o.read_value = {63'd0, mask_mem[v]};
               endcase
            end else begin
               case (fld)
                  FLD_ADDR_LO: msg_addr_mem[v][31:0] = r.wval;
                  FLD_ADDR_HI: msg_addr_mem[v][63:32] = r.wval;
                  FLD_DATA:    msg_data_mem[v] = r.wval;
                  default: begin
                     was = mask_mem[v];
                     mask_mem[v] = r.wval[0];
                     // unmasking a pending vector replays it
                     if (was && !r.wval[0] && live && pba_mem[v / 64][v % 64]) begin
                        pba_mem[v / 64][v % 64] = 1'b0;
                        o.msg_valid = 1'b1;
                        o.msg_addr = msg_addr_mem[v];
                        o.msg_data = msg_data_mem[v];
                     end
                  end
               endcase
            end
         end
         OP_PBA_READ: begin
            q = int'(r.off[14:3]);
            if ((r.size != ACCESS_DWORD && r.size != ACCESS_QWORD) || q >= (n + 63) / 64
                || q >= MAX_VECTORS_DEF / 64) begin
               o.status = ST_IGNORED;
            end else if (r.size == ACCESS_QWORD) begin
               o.read_value = pba_mem[q];
            end else if (r.off[2]) begin
               o.read_value = {32'd0, pba_mem[q][63:32]};
            end else begin
               o.read_value = {32'd0, pba_mem[q][31:0]};
            end
         end
         default: begin
            v = int'(r.vnum);
            if (v >= n) begin
               o.status = ST_RANGE;
            end else if (!live || mask_mem[v]) begin
               pba_mem[v / 64][v % 64] = 1'b1;
               o.status = ST_PENDING;
            end else begin
               o.msg_valid = 1'b1;
               o.msg_addr = msg_addr_mem[v];
               o.msg_data = msg_data_mem[v];
            end
         end
      endcase
      due_outcomes.push_back(o);
   endfunction

   function void check_response(logic [159:0] data, logic [2:0] user);
      msix_outcome got;
      msix_outcome want;
      got.read_value = data[63:0];
      got.msg_addr = data[127:64];
      got.msg_data = data[159:128];
      got.msg_valid = user[0];
      got.status = status_type'(user[2:1]);
      if (due_outcomes.size() == 0) begin
         mismatches++;
         if (reported < 10)
            $display("unexpected response rd=%h mv=%0b ma=%h md=%h st=%0d",
                     got.read_value, got.msg_valid, got.msg_addr, got.msg_data, got.status);
         reported++;
         return;
      end
      want = due_outcomes.pop_front();
      if (got !== want) begin
         mismatches++;
         if (reported < 10) begin
            $display("mismatch exp rd=%h mv=%0b ma=%h md=%h st=%0d",
                     want.read_value, want.msg_valid, want.msg_addr, want.msg_data, want.status);
            $display("         got rd=%h mv=%0b ma=%h md=%h st=%0d",
                     got.read_value, got.msg_valid, got.msg_addr, got.msg_data, got.status);
         end
         reported++;
      end
   endfunction
endclass

module tb_msix_vector_table_and_pending;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASES = 8;
   localparam int RANDOM_PER_PHASE = 215;

   // CSR settings per phase: enable, function mask, vector count
   bit phase_enable [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
   bit phase_fmask  [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
   int phase_count  [PHASES] = '{2048, 2048, 65, 65, 1, 2048, 2048, 100};

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [63:0]   req_tdata = '0;    // [14:0] off, [18:15] size, [50:19] wval, [61:51] vnum
   logic [1:0]    req_tuser = '0;    // [1:0] op
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [159:0]  rsp_tdata;         // [63:0] read, [127:64] msg addr, [159:128] msg data
   logic [2:0]    rsp_tuser;         // [0] msg valid, [2:1] status
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [3:0]    csr_paddr = '0;
   logic [31:0]   csr_pwdata = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   vector_table_shadow sb = new();
   bit  calm = 1'b0;        // suppress idling on both sides while set
   int  stall_left = 0;
   int  cycle_count;

   msix_vector_table_and_pending u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int idle_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 15);
      if (r < 9) return 0;
      if (r < 14) return $urandom_range(1, 3);
      if (r < 15) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Favour a few low vectors so writes, masks and triggers collide; also
   // aim at the top of the live range and, just as often, anywhere at all.
   function automatic logic [10:0] pick_vector(int n);
      int v;
      case ($urandom_range(0, 3))
         0, 1:    v = $urandom_range(0, ((n > 8) ? 8 : n) - 1);
         2:       v = n - 1 - $urandom_range(0, 3);
         default: v = $urandom_range(0, 2047);
      endcase
      if (v < 0) v = 0;
      return v[10:0];
   endfunction

   function automatic msix_request random_request(int n);
      msix_request r;
      int          sel;
      r.op = OP_TRIGGER;
      r.off = 15'($urandom);
      r.size = ACCESS_DWORD;
      r.wval = $urandom;
      r.vnum = 11'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         r.op = OP_TABLE_WRITE;
         r.off = {pick_vector(n), 2'($urandom), 2'b00};
      end else if (sel < 50) begin
         r.op = OP_TABLE_READ;
         r.off = {pick_vector(n), 2'($urandom), 2'b00};
      end else if (sel < 75) begin
         r.vnum = pick_vector(n);
      end else if (sel < 85) begin
         r.op = OP_PBA_READ;
         r.off = 15'($urandom_range(0, ((n + 63) / 64) * 8 - 1));
         r.size = $urandom_range(0, 1) ? ACCESS_QWORD : ACCESS_DWORD;
      end else if (sel < 93) begin
         // broken table access: random size and low offset bits, mostly an odd size or misaligned offset
         r.op = $urandom_range(0, 1) ? OP_TABLE_WRITE : OP_TABLE_READ;
         r.off = {pick_vector(n), 4'($urandom)};
         r.size = 4'($urandom_range(1, 8));
      end else begin
         r.op = op_type'($urandom_range(0, 3));
         r.size = 4'($urandom_range(1, 8));
      end
      return r;
   endfunction

   // Present one request beat and hold it until the block takes it.
   task automatic send_beat(msix_request r);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, r.vnum, r.wval, r.size, r.off};
      req_tuser <= r.op;
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
   endtask

   task automatic send_fields(op_type op, int off, int size, logic [31:0] wval, int vnum);
      msix_request r;
      r.op = op;
      r.off = off[14:0];
      r.size = size[3:0];
      r.wval = wval;
      r.vnum = vnum[10:0];
      send_beat(r);
   endtask

   // Setup cycle, then access cycle; the register lands on the access edge.
   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Drain every outstanding response, then let the pipeline settle.
   task automatic wait_drained();
      while (sb.due_outcomes.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Response side: check each accepted beat, then throttle tready at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tuser);
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = idle_gap();
      end
   end

   // Watchdog: give up well past the slowest legitimate run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) wait_drained();
         // The CSR port takes writes even during the table sweep after reset.
         csr_write(REG_ENABLE, {31'd0, phase_enable[ph]});
         csr_write(REG_FMASK, {31'd0, phase_fmask[ph]});
         csr_write(REG_COUNT, phase_count[ph]);

         if (ph == 0) begin
            // Program vector 5, mask it, latch a trigger, then unmask to replay.
            send_fields(OP_TABLE_WRITE, 'h50, 4, 32'hDEAD_BEEF, 0);
            send_fields(OP_TABLE_WRITE, 'h54, 4, 32'hFFFF_FFFF, 0);
            send_fields(OP_TABLE_WRITE, 'h58, 4, 32'h1234_5678, 0);
            send_fields(OP_TABLE_WRITE, 'h5C, 4, 32'hFFFF_FFFF, 0);
            send_fields(OP_TABLE_READ,  'h5C, 4, 32'h0, 0);
            send_fields(OP_TRIGGER,     'h0,  4, 32'h0, 5);
            send_fields(OP_PBA_READ,    'h0,  8, 32'h0, 0);
            send_fields(OP_PBA_READ,    'h4,  4, 32'h0, 0);
            send_fields(OP_TABLE_WRITE, 'h5C, 4, 32'hFFFF_FFFE, 0);
            send_fields(OP_TRIGGER,     'h0,  4, 32'h0, 5);
            send_fields(OP_PBA_READ,    'h3,  4, 32'h0, 0);
            send_fields(OP_TABLE_READ,  'h50, 4, 32'h0, 0);
            send_fields(OP_TABLE_READ,  'h54, 4, 32'h0, 0);
            send_fields(OP_TABLE_READ,  'h58, 4, 32'h0, 0);
            // bad size and misaligned table accesses
            send_fields(OP_TABLE_READ,  'h50, 8, 32'h0, 0);
            send_fields(OP_TABLE_WRITE, 'h52, 4, 32'hA5A5_A5A5, 0);
            // top entry of the table
            send_fields(OP_TABLE_READ,  'h7FFC, 4, 32'h0, 0);
            send_fields(OP_TABLE_WRITE, 'h7FF4, 4, 32'h8000_0001, 0);
            send_fields(OP_TRIGGER,     'h7FFF, 8, 32'hFFFF_FFFF, 2047);
            send_fields(OP_TRIGGER,     'h0,  1, 32'h0, 0);
            // PBA: last qword, one past the end, far offset, bad size
            send_fields(OP_PBA_READ,    'hF8, 8, 32'h0, 0);
            send_fields(OP_PBA_READ,    'h100, 8, 32'h0, 0);
            send_fields(OP_PBA_READ,    'h7FFF, 4, 32'h0, 0);
            send_fields(OP_PBA_READ,    'h0,  1, 32'h0, 0);
            // unmask a vector that was never masked: no message
            send_fields(OP_TABLE_WRITE, 'h6C, 4, 32'h0, 0);
         end

         // First quarter of each phase runs back to back on both sides.
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            calm = (i < RANDOM_PER_PHASE / 4);
            send_beat(random_request(sb.live_vectors()));
         end
         calm = 1'b0;
         req_tvalid <= 1'b0;
      end

      wait_drained();
      if (sb.mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
